@@ hw/rtl/smq_pkg.sv @@
// Package for the stack with median query: sizes, command and status codes, shared types.
package smq_pkg;

	localparam int KEY_RANGE   = 1024;
	localparam int BUCKET_SIZE = 32;
	localparam int STACK_DEPTH = 1024;
	localparam int NUM_BUCKETS = (KEY_RANGE + BUCKET_SIZE - 1) / BUCKET_SIZE;

	localparam int MODE_W = 2;
	localparam int VAL_W  = 10;
	localparam int STAT_W = 2;
	localparam int KEY_W  = $clog2(KEY_RANGE);
	localparam int BKT_W  = (NUM_BUCKETS > 1) ? $clog2(NUM_BUCKETS) : 1;
	localparam int SADR_W = $clog2(STACK_DEPTH);
	localparam int FILL_W = $clog2(STACK_DEPTH + 1);
	localparam int CNT_W  = FILL_W;

	localparam logic [MODE_W-1:0] MODE_PUSH   = 2'd0;
	localparam logic [MODE_W-1:0] MODE_POP    = 2'd1;
	localparam logic [MODE_W-1:0] MODE_PEEK   = 2'd2;
	localparam logic [MODE_W-1:0] MODE_UNUSED = 2'd3;

	localparam logic [STAT_W-1:0] STATUS_OK    = 2'd0;
	localparam logic [STAT_W-1:0] STATUS_EMPTY = 2'd1;
	localparam logic [STAT_W-1:0] STATUS_FULL  = 2'd2;

	typedef struct packed {
		logic [MODE_W-1:0] op;
		logic [KEY_W-1:0]  key;
	} queue_cmd_t;

	typedef struct packed {
		logic              clearing;
		logic [FILL_W-1:0] fill;
	} back_status_t;

endpackage

@@ hw/rtl/smq_if.sv @@
// Handshake interfaces for the command and result channels.
interface smq_cmd_if;
	logic                      valid;
	logic                      ready;
	logic [smq_pkg::MODE_W-1:0] mode;
	logic [smq_pkg::VAL_W-1:0]  key;
	modport source (output valid, output mode, output key, input ready);
	modport sink   (input valid, input mode, input key, output ready);
endinterface

interface smq_res_if;
	logic                       valid;
	logic                       ready;
	logic [smq_pkg::STAT_W-1:0] status;
	logic [smq_pkg::VAL_W-1:0]  value;
	modport source (output valid, output status, output value, input ready);
	modport sink   (input valid, input status, input value, output ready);
endinterface

@@ hw/rtl/smq_ram.sv @@
// Generic single-write, single-read RAM with a registered read port.
module smq_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule

@@ hw/rtl/smq_front.sv @@
// Front end: accepts command words, drops the unused mode and queues the rest.
module smq_front (
	input  logic                clk,
	input  logic                arst_n,
	smq_cmd_if.sink             cmd,
	output logic                q_valid,
	input  logic                q_ready,
	output smq_pkg::queue_cmd_t q_cmd
);
	import smq_pkg::*;

	queue_cmd_t  entry_q [2];
	logic        wr_ptr_q;
	logic        rd_ptr_q;
	logic [1:0]  count_q;
	logic        take;
	logic        keep;
	logic        pop;

	assign cmd.ready = (count_q != 2'd2);
	assign take      = cmd.valid && cmd.ready;
	// Mode 3 means nothing; the word is taken and forgotten.
	assign keep      = take && (cmd.mode != MODE_UNUSED);
	assign q_valid   = (count_q != 2'd0);
	assign q_cmd     = entry_q[rd_ptr_q];
	assign pop       = q_valid && q_ready;

	always_ff @(posedge clk) begin
		if (keep) begin
			entry_q[wr_ptr_q] <= '{op: cmd.mode, key: cmd.key[KEY_W-1:0]};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (keep) wr_ptr_q <= ~wr_ptr_q;
			if (pop) rd_ptr_q <= ~rd_ptr_q;
			if (keep && !pop) count_q <= count_q + 2'd1;
			else if (pop && !keep) count_q <= count_q - 2'd1;
		end
	end
endmodule

@@ hw/rtl/smq_back.sv @@
// Back end: stack, histograms, median walk and the result register.
module smq_back (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  q_valid,
	output logic                  q_ready,
	input  smq_pkg::queue_cmd_t   q_cmd,
	smq_res_if.source             res,
	output smq_pkg::back_status_t stat
);
	import smq_pkg::*;

	localparam logic [2:0] S_CLEAR   = 3'd0;
	localparam logic [2:0] S_IDLE    = 3'd1;
	localparam logic [2:0] S_PUSH_WR = 3'd2;
	localparam logic [2:0] S_POP_RD  = 3'd3;
	localparam logic [2:0] S_POP_WR  = 3'd4;
	localparam logic [2:0] S_WALK_B  = 3'd5;
	localparam logic [2:0] S_K_RD    = 3'd6;
	localparam logic [2:0] S_K_CHK   = 3'd7;

	logic [2:0]        state_q;
	logic [FILL_W-1:0] fill_q;
	logic [KEY_W-1:0]  key_q;
	logic [KEY_W-1:0]  clr_q;
	logic [CNT_W-1:0]  bucket_q [NUM_BUCKETS];
	logic [FILL_W-1:0] rank_q;
	logic [FILL_W-1:0] sum_q;
	logic [BKT_W-1:0]  b_q;
	logic              out_valid_q;
	logic [STAT_W-1:0] out_status_q;
	logic [VAL_W-1:0]  out_value_q;

	logic              st_we;
	logic [SADR_W-1:0] st_raddr;
	logic [VAL_W-1:0]  st_rdata;
	logic              kc_we;
	logic [KEY_W-1:0]  kc_waddr;
	logic [CNT_W-1:0]  kc_wdata;
	logic [KEY_W-1:0]  kc_raddr;
	logic [CNT_W-1:0]  kc_rdata;
	logic [KEY_W-1:0]  top_key;
	logic [FILL_W:0]   sum_b;
	logic [FILL_W:0]   sum_k;
	logic [FILL_W:0]   fill_inc;
	logic [BKT_W-1:0]  kbkt;

	assign q_ready    = (state_q == S_IDLE) && !out_valid_q;
	assign res.valid  = out_valid_q;
	assign res.status = out_status_q;
	assign res.value  = out_value_q;
	assign stat       = '{clearing: (state_q == S_CLEAR), fill: fill_q};

	assign top_key  = st_rdata[KEY_W-1:0];
	assign sum_b    = {1'b0, sum_q} + {1'b0, bucket_q[b_q]};
	assign sum_k    = {1'b0, sum_q} + {1'b0, kc_rdata};
	assign fill_inc = {1'b0, fill_q} + {{FILL_W{1'b0}}, 1'b1};
	assign kbkt     = BKT_W'(key_q / BUCKET_SIZE);

	assign st_we    = (state_q == S_IDLE) && q_valid && q_ready && (q_cmd.op == MODE_PUSH)
		&& (fill_q < FILL_W'(STACK_DEPTH));
	assign st_raddr = SADR_W'(fill_q - FILL_W'(1));

	always_comb begin
		kc_we    = 1'b0;
		kc_waddr = key_q;
		kc_wdata = '0;
		kc_raddr = key_q;
		unique case (state_q)
			S_CLEAR: begin
				kc_we    = 1'b1;
				kc_waddr = clr_q;
			end
			S_IDLE: kc_raddr = q_cmd.key;
			S_PUSH_WR: begin
				kc_we    = 1'b1;
				kc_wdata = kc_rdata + CNT_W'(1);
			end
			S_POP_RD: kc_raddr = top_key;
			S_POP_WR: begin
				kc_we    = (kc_rdata != '0);
				kc_wdata = kc_rdata - CNT_W'(1);
			end
			default: kc_raddr = key_q;
		endcase
	end

	smq_ram #(.WIDTH(VAL_W), .DEPTH(STACK_DEPTH)) u_stack (
		.clk(clk), .we(st_we), .waddr(fill_q[SADR_W-1:0]),
		.wdata(VAL_W'(q_cmd.key)), .raddr(st_raddr), .rdata(st_rdata)
	);

	smq_ram #(.WIDTH(CNT_W), .DEPTH(KEY_RANGE)) u_counts (
		.clk(clk), .we(kc_we), .waddr(kc_waddr), .wdata(kc_wdata),
		.raddr(kc_raddr), .rdata(kc_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_CLEAR;
			fill_q       <= '0;
			clr_q        <= '0;
			out_valid_q  <= 1'b0;
			out_status_q <= STATUS_OK;
			out_value_q  <= '0;
			key_q        <= '0;
			rank_q       <= '0;
			sum_q        <= '0;
			b_q          <= '0;
			for (int i = 0; i < NUM_BUCKETS; i++) bucket_q[i] <= '0;
		end else begin
			if (out_valid_q && res.ready) out_valid_q <= 1'b0;
			unique case (state_q)
				S_CLEAR: begin
					clr_q <= clr_q + KEY_W'(1);
					if (clr_q == KEY_W'(KEY_RANGE - 1)) state_q <= S_IDLE;
				end
				S_IDLE: begin
					if (q_valid && q_ready) begin
						key_q <= q_cmd.key;
						priority case (1'b1)
							(q_cmd.op == MODE_PUSH): begin
								if (fill_q >= FILL_W'(STACK_DEPTH)) begin
									out_valid_q  <= 1'b1;
									out_status_q <= STATUS_FULL;
									out_value_q  <= '0;
								end else begin
									fill_q  <= fill_inc[FILL_W-1:0];
									state_q <= S_PUSH_WR;
								end
							end
							(fill_q == '0): begin
								out_valid_q  <= 1'b1;
								out_status_q <= STATUS_EMPTY;
								out_value_q  <= '0;
							end
							(q_cmd.op == MODE_POP): begin
								fill_q  <= fill_q - FILL_W'(1);
								state_q <= S_POP_RD;
							end
							default: begin
								rank_q  <= fill_inc[FILL_W:1];
								sum_q   <= '0;
								b_q     <= '0;
								state_q <= S_WALK_B;
							end
						endcase
					end
				end
				S_PUSH_WR: begin
					bucket_q[kbkt] <= bucket_q[kbkt] + CNT_W'(1);
					state_q        <= S_IDLE;
				end
				S_POP_RD: begin
					key_q   <= top_key;
					state_q <= S_POP_WR;
				end
				S_POP_WR: begin
					if (bucket_q[kbkt] != '0) bucket_q[kbkt] <= bucket_q[kbkt] - CNT_W'(1);
					out_valid_q  <= 1'b1;
					out_status_q <= STATUS_OK;
					out_value_q  <= VAL_W'(key_q);
					state_q      <= S_IDLE;
				end
				S_WALK_B: begin
					if ((b_q != BKT_W'(NUM_BUCKETS - 1)) && (sum_b < {1'b0, rank_q})) begin
						sum_q <= sum_b[FILL_W-1:0];
						b_q   <= b_q + BKT_W'(1);
					end else begin
						key_q   <= KEY_W'(KEY_W'(b_q) * KEY_W'(BUCKET_SIZE));
						state_q <= S_K_RD;
					end
				end
				S_K_RD: state_q <= S_K_CHK;
				S_K_CHK: begin
					if ((key_q != KEY_W'(KEY_RANGE - 1)) && (sum_k < {1'b0, rank_q})) begin
						sum_q   <= sum_k[FILL_W-1:0];
						key_q   <= key_q + KEY_W'(1);
						state_q <= S_K_RD;
					end else begin
						out_valid_q  <= 1'b1;
						out_status_q <= STATUS_OK;
						out_value_q  <= VAL_W'(key_q);
						state_q      <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end
endmodule

@@ hw/rtl/stack_with_median_query.sv @@
// Top level of the stack with median query: front end, command queue and back end.
// A user first needs to know the timing. After reset the back end clears all 1024 entries
// of the key count memory, one entry per cycle, and carries out no word during that time; the
// front end still accepts up to two words into its queue, then holds ready low. Each
// command word then runs on its own in the back end: a push writes the stack and then
// updates the key and bucket counts, a pop reads the top key and then decrements its counts
// and returns it, a rejected push or an empty pop or peek answers from the idle state, and a
// median peek walks the bucket counts (at most 32) and then reads the key counts inside the
// chosen bucket (at most 32). The peek time is set by the bucket walk and by the single read
// port of the key count memory, whose registered read gives each key examined a read state
// and a check state. A two-word queue sits between the front end and the back end, so up to
// two more words are accepted while a result waits on the output. Mode 3 words are accepted
// and ignored. A successful push returns no result word.
module stack_with_median_query (
	input  logic      clk,
	input  logic      arst_n,
	smq_cmd_if.sink   cmd,
	smq_res_if.source res
);
	import smq_pkg::*;

	logic         q_valid;
	logic         q_ready;
	queue_cmd_t   q_cmd;
	back_status_t stat;

	// The front end only filters and buffers words; all stack and count state lives in the back end.
	smq_front u_front (
		.clk(clk), .arst_n(arst_n), .cmd(cmd),
		.q_valid(q_valid), .q_ready(q_ready), .q_cmd(q_cmd)
	);

	// The back end owns the stack memory, both histograms and the result register.
	smq_back u_back (
		.clk(clk), .arst_n(arst_n),
		.q_valid(q_valid), .q_ready(q_ready), .q_cmd(q_cmd),
		.res(res), .stat(stat)
	);

	// The stack never holds more keys than it has room for.
	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		stat.fill <= FILL_W'(STACK_DEPTH))
		else $error("stack fill above depth");

	// No result can appear while the clearing pass runs.
	a_no_res_clear: assert property (@(posedge clk) disable iff (!arst_n)
		stat.clearing |-> !res.valid)
		else $error("result during clearing pass");

	// The fill count moves by one key at a time.
	a_fill_step: assert property (@(posedge clk) disable iff (!arst_n)
		!$stable(stat.fill) |-> (stat.fill == $past(stat.fill) + FILL_W'(1)) ||
			(stat.fill == $past(stat.fill) - FILL_W'(1)))
		else $error("fill count jumped");

	// Error results always carry a zero value.
	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(res.valid && (res.status != STATUS_OK)) |-> (res.value == '0))
		else $error("error result with nonzero value");

endmodule
